[rtl/core/spum_pkg.sv]
package spum_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Reported counts are fixed at 7 bits
  localparam int OUT_W  = 7;
  localparam int DATA_W = 32;

  // Operation codes (s_axis_tuser)
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes (m_axis_tuser)
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  // Keep the low OUT_W bits of a count, zero-extending narrow counts
  function automatic logic [OUT_W-1:0] fit_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_W-1:0] wide;
    wide = {{OUT_W{1'b0}}, c};
    return wide[OUT_W-1:0];
  endfunction

endpackage

[rtl/core/spum_ram.sv]
module spum_ram
  import spum_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [PTR_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [PTR_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold the last word when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/stack_pop_until_match.sv]
// Bounded stack of 32-bit values with push and pop-until-match.
//
// Input channel s_axis: one transaction per operation. tuser carries the
// operation (push or pop until match), tdata the value to push or to find.
// Output channel m_axis: exactly one transaction per input transaction, in
// order. tuser carries the status, tdata the removed count and the depth.
//
// Timing: a push result is valid the cycle after the push is accepted, and so
// is the result of a pop on an empty stack. Any other pop reads the stack from
// the top down, one entry per cycle, through the single read port of the entry
// memory, and its result is registered once a match or the bottom entry has
// been examined.
// One operation is in flight at a time; the next is taken once the current
// one has produced its result and the output register is free or draining.
//
// Reset: the stack is empty after rst and no result is pending; the entry
// memory is not cleared, since only entries below the top are ever read.
// Stall: while m_axis_tready is low the result register holds its
// transaction and s_axis_tready stays low.
module stack_pop_until_match
  import spum_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] removed_count, [13:7] depth_after, [15:14] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  top;
  logic [PTR_W-1:0]  pos;        // entry whose word sits in rd_data
  logic [DATA_W-1:0] key;        // value being searched for

  logic              out_valid;
  logic [1:0]        out_status;
  logic [OUT_W-1:0]  out_removed;
  logic [OUT_W-1:0]  out_depth;

  logic              we;
  logic [PTR_W-1:0]  waddr;
  logic              re;
  logic [PTR_W-1:0]  raddr;
  logic [DATA_W-1:0] rd_data;

  logic              in_fire;
  logic              out_free;
  logic              is_full;
  logic              hit;
  logic              search_done;
  logic              res_load;
  logic [CNT_W-1:0]  top_less1;
  logic [CNT_W-1:0]  pos_ext;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_full       = (top == CNT_W'(STACK_DEPTH));
  assign top_less1     = top - CNT_W'(1);
  assign pos_ext       = CNT_W'(pos);
  assign hit           = (rd_data == key);
  assign search_done   = (state == S_SEARCH) && (hit || pos == '0);
  // a push or a pop on an empty stack finishes at once, a search when it ends
  assign res_load      = (in_fire && ((s_axis_tuser[0] == OP_PUSH) || top == '0))
                         || search_done;

  // Write on an accepted push with room; read the top entry to start a pop,
  // then step down one entry per cycle until a hit or the bottom.
  always_comb begin
    we    = in_fire && (s_axis_tuser[0] == OP_PUSH) && !is_full;
    waddr = top[PTR_W-1:0];
    re    = 1'b0;
    raddr = top_less1[PTR_W-1:0];
    if (in_fire && (s_axis_tuser[0] == OP_POP) && top != '0) begin
      re    = 1'b1;
      raddr = top_less1[PTR_W-1:0];
    end else if (state == S_SEARCH && !search_done) begin
      re    = 1'b1;
      raddr = pos - PTR_W'(1);
    end
  end

  spum_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (s_axis_tdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      // hold the result until taken; load a new one when an operation ends
      out_valid <= res_load || (out_valid && !m_axis_tready);
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            key <= s_axis_tdata;
            if (s_axis_tuser[0] == OP_PUSH) begin
              out_removed <= '0;
              if (is_full) begin
                out_status <= ST_FULL;
                out_depth  <= fit_out(top);
              end else begin
                out_status <= ST_OK;
                out_depth  <= fit_out(top + CNT_W'(1));
                top        <= top + CNT_W'(1);
              end
            end else if (top == '0) begin
              // empty stack: nothing can match
              out_status  <= ST_NO_MATCH;
              out_removed <= '0;
              out_depth   <= '0;
            end else begin
              pos   <= top_less1[PTR_W-1:0];
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            out_status  <= ST_OK;
            out_removed <= fit_out(top - pos_ext);
            out_depth   <= fit_out(pos_ext);
            top         <= pos_ext;
            state       <= S_IDLE;
          end else if (pos == '0) begin
            out_status  <= ST_NO_MATCH;
            out_removed <= fit_out(top);
            out_depth   <= '0;
            top         <= '0;
            state       <= S_IDLE;
          end else begin
            pos <= pos - PTR_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {2'b00, out_depth, out_removed};

  // Stack never holds more than its capacity
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= CNT_W'(STACK_DEPTH))
    else $error("stack count above capacity");

  // The entry under compare always lies below the top
  a_pos_below_top: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (pos_ext < top))
    else $error("search position at or above top");

  // A finishing search always finds the result register free
  a_done_slot_free: assert property (@(posedge clk) disable iff (rst)
    search_done |-> out_free)
    else $error("search finished while result register busy");

  // A push with room grows the stack by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    we |=> (top == $past(top) + CNT_W'(1)))
    else $error("push did not advance top");

endmodule

[verif/tb_stack_pop_until_match.sv]
`timescale 1ns / 1ps

module tb_stack_pop_until_match;
  import spum_pkg::*;

  // Longest run of cycles with no transaction on either side before the run is
  // declared hung. One pop walks at most STACK_DEPTH entries, and the receiver
  // stalls at random on top of that.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 770;
  localparam int IDLE_PCT       = 26;

  typedef struct packed {
    logic [1:0]       status;
    logic [OUT_W-1:0] removed;
    logic [OUT_W-1:0] depth;
  } stack_result_t;

  // One row of the directed sequence: the operation is repeated reps times.
  // Where typed is set, want is the result read straight off the spec.
  typedef struct packed {
    logic          op;
    logic [31:0]   val;
    logic [7:0]    reps;
    logic          typed;
    stack_result_t want;
  } dir_row_t;

  localparam stack_result_t NONE = '{ST_OK, 7'd0, 7'd0};

  localparam dir_row_t DIRECTED_ROWS [0:16] = '{
    // pop on empty stack: nothing to match, stack stays empty
    '{OP_POP,  32'h0000_0000, 8'd1,  1'b1, '{ST_NO_MATCH, 7'd0, 7'd0}},
    // extremes of the value field
    '{OP_PUSH, 32'h8000_0000, 8'd1,  1'b1, '{ST_OK, 7'd0, 7'd1}},
    '{OP_PUSH, 32'h7FFF_FFFF, 8'd1,  1'b1, '{ST_OK, 7'd0, 7'd2}},
    '{OP_PUSH, 32'h0000_0000, 8'd1,  1'b1, '{ST_OK, 7'd0, 7'd3}},
    '{OP_PUSH, 32'hFFFF_FFFF, 8'd1,  1'b1, '{ST_OK, 7'd0, 7'd4}},
    '{OP_PUSH, 32'h7FFF_FFFF, 8'd1,  1'b1, '{ST_OK, 7'd0, 7'd5}},
    // duplicate value: the copy nearest the top is the one that matches
    '{OP_POP,  32'h7FFF_FFFF, 8'd1,  1'b1, '{ST_OK, 7'd1, 7'd4}},
    // match at the very bottom removes everything
    '{OP_POP,  32'h8000_0000, 8'd1,  1'b1, '{ST_OK, 7'd4, 7'd0}},
    '{OP_PUSH, 32'h1234_5678, 8'd1,  1'b1, '{ST_OK, 7'd0, 7'd1}},
    '{OP_POP,  32'h5555_5555, 8'd1,  1'b1, '{ST_NO_MATCH, 7'd1, 7'd0}},
    // fill to the brim, then push on the full stack
    '{OP_PUSH, 32'hAAAA_AAAA, 8'd64, 1'b0, NONE},
    '{OP_PUSH, 32'h5555_5555, 8'd1,  1'b1, '{ST_FULL, 7'd0, 7'd64}},
    '{OP_POP,  32'hAAAA_AAAA, 8'd1,  1'b1, '{ST_OK, 7'd1, 7'd63}},
    '{OP_PUSH, 32'h0000_0000, 8'd1,  1'b1, '{ST_OK, 7'd0, 7'd64}},
    // miss on a full stack walks every entry and clears it
    '{OP_POP,  32'h1357_2468, 8'd1,  1'b1, '{ST_NO_MATCH, 7'd64, 7'd0}},
    '{OP_PUSH, 32'hDEAD_BEEF, 8'd3,  1'b0, NONE},
    '{OP_POP,  32'hDEAD_BEEF, 8'd1,  1'b0, NONE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Predictor state: a shadow of the stack contents and its fill level
  logic [31:0] shadow_stack [STACK_DEPTH];
  int          shadow_fill = 0;

  // Results owed by the block, oldest first
  stack_result_t pending_results [$];
  stack_result_t head;

  // Set during a stretch of the random part in which neither side idles
  logic steady = 1'b0;

  int mismatches  = 0;
  int quiet_count = 0;
  int push_ops    = 0;
  int pop_ops     = 0;
  int full_drops  = 0;
  int pop_hits    = 0;
  int pop_misses  = 0;
  int peak_fill   = 0;

  stack_pop_until_match dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] value
    .s_axis_tuser  (s_axis_tuser),   // [0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [6:0] removed_count, [13:7] depth_after, [15:14] zero
    .m_axis_tuser  (m_axis_tuser)    // [1:0] status
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the shadow stack and return what the block must report.
  function automatic stack_result_t apply_stack_op(input logic op, input logic [31:0] val);
    stack_result_t r;
    int            pos;
    r = NONE;
    if (op == OP_PUSH) begin
      push_ops++;
      if (shadow_fill >= STACK_DEPTH) begin
        r.status = ST_FULL;
        full_drops++;
      end else begin
        shadow_stack[shadow_fill] = val;
        shadow_fill++;
      end
    end else begin
      pop_ops++;
      // search from the top down for the nearest equal entry
      pos = shadow_fill - 1;
      while (pos >= 0 && shadow_stack[pos] != val) pos--;
      if (pos >= 0) begin
        r.removed   = OUT_W'(shadow_fill - pos);
        shadow_fill = pos;
        pop_hits++;
      end else begin
        r.status    = ST_NO_MATCH;
        r.removed   = OUT_W'(shadow_fill);
        shadow_fill = 0;
        pop_misses++;
      end
    end
    r.depth = OUT_W'(shadow_fill);
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    return r;
  endfunction

  // Offer one transaction, hold it until accepted, then log what it must produce.
  task automatic send_op(input logic op, input logic [31:0] val, input logic typed,
                         input stack_result_t typed_want);
    stack_result_t want;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = apply_stack_op(op, val);
    if (typed) want = typed_want;
    pending_results.push_back(want);
  endtask

  // Receiver: stall at random, compare every accepted result with the oldest
  // outstanding prediction.
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d tdata 0x%h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (m_axis_tuser !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[6:0] !== head.removed) begin
          $error("removed_count: expected %0d, got %0d", head.removed, m_axis_tdata[6:0]);
          mismatches++;
        end
        if (m_axis_tdata[13:7] !== head.depth) begin
          $error("depth_after: expected %0d, got %0d", head.depth, m_axis_tdata[13:7]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", quiet_count);
      $display("tb_stack_pop_until_match: errors");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    logic [31:0] value_pool [6];
    int          push_pct;
    int          pick;
    logic        op;
    logic [31:0] val;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: walk the table
    foreach (DIRECTED_ROWS[r]) begin
      repeat (DIRECTED_ROWS[r].reps)
        send_op(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].val,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    // Random part. Pushes draw mostly from a small pool so that pops find
    // matches deep in the stack; pops mostly name an entry that is held.
    foreach (value_pool[k]) value_pool[k] = $urandom();
    push_pct = 55;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 400 && i < 550);
      // swing between draining, balanced and filling phases
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 25;
          1: push_pct = 55;
          default: push_pct = 92;
        endcase
      end
      if (i % 60 == 0) value_pool[$urandom_range(5)] = $urandom();

      if ($urandom_range(99) < push_pct) begin
        op  = OP_PUSH;
        val = ($urandom_range(99) < 70) ? value_pool[$urandom_range(5)] : $urandom();
      end else begin
        op   = OP_POP;
        pick = $urandom_range(99);
        if (pick < 60 && shadow_fill > 0)
          val = shadow_stack[$urandom_range(shadow_fill - 1)];
        else if (pick < 80)
          val = value_pool[$urandom_range(5)];
        else
          val = $urandom();
      end
      send_op(op, val, 1'b0, NONE);
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every outstanding result, then let a full pop's worth pass
    while (pending_results.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);

    $display("ran %0d pushes (%0d dropped on full stack) and %0d pops (%0d matched, %0d cleared)",
             push_ops, full_drops, pop_ops, pop_hits, pop_misses);
    $display("peak depth %0d of %0d, %0d mismatches", peak_fill, STACK_DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("tb_stack_pop_until_match: clean");
    end else begin
      $display("tb_stack_pop_until_match: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/spum_pkg.sv
rtl/core/spum_ram.sv
rtl/core/stack_pop_until_match.sv
verif/tb_stack_pop_until_match.sv
